@@ hw/rtl/cltw_pkg.sv @@
`timescale 1ns / 1ps

package cltw_pkg;

   // table method codes
   localparam logic [1:0] METHOD_RAW     = 2'd0;
   localparam logic [1:0] METHOD_ONE_BIT = 2'd1;
   localparam logic [1:0] METHOD_TWO_BIT = 2'd2;
   localparam logic [1:0] METHOD_NONE    = 2'd3;

   // escape prefix "11" ahead of a raw 4-bit length
   localparam logic [5:0] ESCAPE_MARK = 6'h30;
   localparam logic [2:0] RAW_BITS    = 3'd4;
   localparam logic [2:0] ESCAPE_BITS = 3'd6;
   localparam logic [2:0] DELTA_BITS  = 3'd2;

   // output queue depth and pointer width
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   // one encoded symbol: value right-aligned, bit count
   typedef struct packed {
      logic [5:0] bits;
      logic [2:0] count;
   } symbol_type;

endpackage

@@ hw/rtl/code_length_table_writer.sv @@
`timescale 1ns / 1ps

// channel  | ports      | tdata               | tuser        | tlast
// ---------+------------+---------------------+--------------+-----------
// req in   | req_t*     | [3:0] code_length   | first_entry  | last_entry
// rsp out  | rsp_t*     | [7:0] out_byte      | -            | last_byte
// csr      | csr_we/wd  | [1:0] table_method  | -            | -
//
// one code length per cycle enters an input register while req_tready is high;
// it is encoded from that register, writing zero, one or two bytes into a
// four-entry output queue; the input register advances only while the queue
// has two free entries, so sustained rate is one entry per cycle until the byte
// side (one per cycle) lags; a request passes the input register, then the queue
// synchronous reset clears the bit holder, the queue and table_method (raw)
module code_length_table_writer
   import cltw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] code_length, [7:4] zero
   input  logic       req_tuser,   // [0] first_entry
   input  logic       req_tlast,   // last_entry
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_byte
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);

   logic [1:0]       method_ff;
   logic             in_valid_ff;
   logic [3:0]       in_len_ff;
   logic             in_first_ff;
   logic             in_last_ff;
   logic [6:0]       held_bits_ff, held_bits_in;
   logic [2:0]       held_count_ff, held_count_in;
   logic [3:0]       prev_len_ff;
   logic [7:0]       q_data_ff [QUEUE_DEPTH];
   logic             q_last_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;

   logic             proceed;
   logic             pop;
   symbol_type       sym;
   logic [4:0]       prev_plus;
   logic             same, up_one, down_one;
   logic [12:0]      acc;
   logic [3:0]       total;
   logic [3:0]       rem;
   logic             wr_a, wr_b;
   logic [7:0]       byte_a, byte_b;
   logic             last_a;
   logic [6:0]       rem_bits;
   logic [PTR_W-1:0] wr_ptr_b;

   // handshake control
   assign proceed    = in_valid_ff && (count_ff <= (PTR_W+1)'(QUEUE_DEPTH - 2));
   assign req_tready = !in_valid_ff || proceed;
   assign pop        = rsp_tvalid && rsp_tready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= METHOD_RAW;
      end else if (csr_we) begin
         method_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_len_ff   <= req_tdata[3:0];
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   // symbol selection
   always_comb begin
      prev_plus = {1'b0, prev_len_ff} + 5'd1;
      same      = (in_len_ff == prev_len_ff);
      up_one    = ({1'b0, in_len_ff} == prev_plus);
      down_one  = (prev_len_ff != 4'd0) && (in_len_ff == prev_len_ff - 4'd1);
      sym.bits  = 6'd0;
      sym.count = 3'd0;
      if (method_ff != METHOD_NONE) begin
         if (in_first_ff || method_ff == METHOD_RAW) begin
            sym.bits  = {2'b00, in_len_ff};
            sym.count = RAW_BITS;
         end else if (method_ff == METHOD_ONE_BIT) begin
            if (same) begin
               sym.bits  = 6'd0;
               sym.count = 3'd1;
            end else if (up_one) begin
               sym.bits  = 6'd2;
               sym.count = DELTA_BITS;
            end else begin
               sym.bits  = ESCAPE_MARK | {2'b00, in_len_ff};
               sym.count = ESCAPE_BITS;
            end
         end else begin
            if (down_one) begin
               sym.bits  = 6'd0;
               sym.count = DELTA_BITS;
            end else if (same) begin
               sym.bits  = 6'd1;
               sym.count = DELTA_BITS;
            end else if (up_one) begin
               sym.bits  = 6'd2;
               sym.count = DELTA_BITS;
            end else begin
               sym.bits  = ESCAPE_MARK | {2'b00, in_len_ff};
               sym.count = ESCAPE_BITS;
            end
         end
      end
   end

   // bit packing and byte extraction
   always_comb begin
      acc      = ({6'd0, held_bits_ff} << sym.count) | {7'd0, sym.bits};
      total    = {1'b0, held_count_ff} + {1'b0, sym.count};
      wr_a     = proceed && (total >= 4'd8);
      rem      = (total >= 4'd8) ? total - 4'd8 : total;
      byte_a   = 8'(acc >> rem);
      last_a   = in_last_ff && (rem == 4'd0);
      rem_bits = 7'(acc & ((13'd1 << rem) - 13'd1));
      wr_b     = proceed && in_last_ff && (rem != 4'd0);
      byte_b   = 8'({1'b0, rem_bits} << (4'd8 - rem));
      wr_ptr_b = wr_ptr_ff + PTR_W'(wr_a);

      held_bits_in  = held_bits_ff;
      held_count_in = held_count_ff;
      if (proceed) begin
         if (in_last_ff) begin
            held_bits_in  = 7'd0;
            held_count_in = 3'd0;
         end else begin
            held_bits_in  = rem_bits;
            held_count_in = rem[2:0];
         end
      end
   end

   // bit holder and previous length
   always_ff @(posedge clock) begin
      if (reset) begin
         held_bits_ff  <= 7'd0;
         held_count_ff <= 3'd0;
         prev_len_ff   <= 4'd0;
      end else begin
         held_bits_ff  <= held_bits_in;
         held_count_ff <= held_count_in;
         if (proceed) begin
            prev_len_ff <= in_len_ff;
         end
      end
   end

   // output queue storage
   always_ff @(posedge clock) begin
      if (wr_a) begin
         q_data_ff[wr_ptr_ff] <= byte_a;
         q_last_ff[wr_ptr_ff] <= last_a;
      end
      if (wr_b) begin
         q_data_ff[wr_ptr_b] <= byte_b;
         q_last_ff[wr_ptr_b] <= 1'b1;
      end
   end

   // output queue pointers
   assign count_in = count_ff + (PTR_W+1)'(wr_a) + (PTR_W+1)'(wr_b) - (PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(wr_a) + PTR_W'(wr_b);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

   // result channel
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = q_data_ff[rd_ptr_ff];
   assign rsp_tlast  = q_last_ff[rd_ptr_ff];

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(QUEUE_DEPTH))
      else $error("output queue overflow");

   a_room_on_advance: assert property (@(posedge clock) disable iff (reset)
      proceed |-> count_ff <= (PTR_W+1)'(QUEUE_DEPTH - 2))
      else $error("entry encoded without room for two bytes");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      proceed && in_last_ff |=> held_count_ff == 3'd0)
      else $error("bits held after last entry");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proceed |=> in_valid_ff)
      else $error("stalled entry dropped");

endmodule
